/* sv/isort_pkg.sv */
// ----------------------------------------------------------------------------
// isort_pkg: shared types for the insertion sorter
// Payload structs for both channels and the control word for the cell chain.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int unsigned ValueW = 32;

  // Input item: one element of the set, last marks the end of the set
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_item_t;

  // Result item: next element in ascending order
  typedef struct packed {
    logic signed [ValueW-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  // Chain control, common to every cell
  typedef struct packed {
    logic insert;  // insert the broadcast value in order
    logic pop;     // shift every entry one cell toward the output
  } cell_ctrl_t;

endpackage

/* sv/insertion_sorter_unit.sv */
// Stable insertion sorter for sets of signed 32-bit values. While a set loads,
// one element is taken per cycle and dropped into place in a chain of
// MAX_ITEMS cells, each comparing its entry against the broadcast value in the
// same cycle. The element marked last ends the set; the chain then drains one
// result per cycle from cell 0 while out_ready is high (ascending order,
// last_res on the final one), and no input is taken until the drain is done.
// Elements past MAX_ITEMS are dropped and every result of that set carries
// overflow.
// ----------------------------------------------------------------------------
// insertion_sorter_unit: top level of the insertion sorter
// Occupancy count, load/drain control and the chain of sorting cells.
// ----------------------------------------------------------------------------
module insertion_sorter_unit
  import isort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            draining_r, draining_nxt;
  logic            ovf_r, ovf_nxt;

  logic            in_xfer, out_xfer, full;
  cell_ctrl_t      ctrl;

  logic                     occ   [MAX_ITEMS];
  logic                     gt    [MAX_ITEMS];
  logic signed [ValueW-1:0] value [MAX_ITEMS];

  // Handshake
  assign in_ready  = !draining_r;
  assign out_valid = draining_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign full      = (count_r == CntW'(MAX_ITEMS));

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.pop    = out_xfer;

  // Result from the head of the chain
  assign out_data.value_res = value[0];
  assign out_data.last_res  = (count_r == CntW'(1));
  assign out_data.overflow  = ovf_r;

  // Next control state
  always_comb begin
    count_nxt    = count_r;
    draining_nxt = draining_r;
    ovf_nxt      = ovf_r;
    if (in_xfer) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CntW'(1);
      end
      if (in_data.last) begin
        draining_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      count_nxt = count_r - CntW'(1);
      if (count_r == CntW'(1)) begin
        draining_nxt = 1'b0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      draining_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      draining_r <= draining_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Cell chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_r);

    if (i == 0) begin : g_head
      isort_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_value   (in_data.value),
        .occ         (occ[i]),
        .occ_left    (1'b1),
        .gt_left     (1'b0),
        .value_left  (in_data.value),
        .value_right (value[(i + 1) % MAX_ITEMS]),
        .gt          (gt[i]),
        .value       (value[i])
      );
    end else if (i == MAX_ITEMS - 1) begin : g_tail
      isort_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_value   (in_data.value),
        .occ         (occ[i]),
        .occ_left    (occ[i-1]),
        .gt_left     (gt[i-1]),
        .value_left  (value[i-1]),
        .value_right (value[i]),
        .gt          (gt[i]),
        .value       (value[i])
      );
    end else begin : g_mid
      isort_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_value   (in_data.value),
        .occ         (occ[i]),
        .occ_left    (occ[i-1]),
        .gt_left     (gt[i-1]),
        .value_left  (value[i-1]),
        .value_right (value[i+1]),
        .gt          (gt[i]),
        .value       (value[i])
      );
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MAX_ITEMS))
    else $error("entry count above capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (count_r != '0))
    else $error("draining with an empty chain");

  a_final_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_data.last_res) |=> (!draining_r && count_r == '0 && !ovf_r))
    else $error("set not closed after final result");

  a_ovf_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && full) |=> ovf_r)
    else $error("dropped element did not raise overflow");
`endif

endmodule

/* sv/isort_cell.sv */
// ----------------------------------------------------------------------------
// isort_cell: one slot of the sorting chain
// Holds one value, compares it against the broadcast value and takes the left
// neighbor's or the broadcast value (insert) or the right neighbor's (pop).
// ----------------------------------------------------------------------------
module isort_cell
  import isort_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic signed [ValueW-1:0] new_value,
  input  logic                     occ,        // this slot holds an entry
  input  logic                     occ_left,   // left slot holds an entry
  input  logic                     gt_left,    // left entry is greater than new_value
  input  logic signed [ValueW-1:0] value_left,
  input  logic signed [ValueW-1:0] value_right,
  output logic                     gt,
  output logic signed [ValueW-1:0] value
);

  logic signed [ValueW-1:0] value_r;
  logic signed [ValueW-1:0] value_nxt;
  logic                     take;

  // Strictly greater keeps equal values in arrival order
  assign gt    = occ && (value_r > new_value);
  assign value = value_r;

  // Move when this entry must make room, or when this is the first free slot
  assign take = gt || (!occ && occ_left);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.insert && take) begin
      value_nxt = gt_left ? value_left : new_value;
    end else if (ctrl.pop) begin
      value_nxt = value_right;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
